/* rtl/m3i_pkg.sv */
`default_nettype none

package m3i_pkg;

    localparam int ENT_W = 32;
    localparam int NLANE = 9;
    localparam int COF_W = 64;
    localparam int DET_W = 98;
    localparam int DM_W  = 96;
    localparam int NQ    = 33;
    localparam int QR_W  = NQ + 1;

    localparam logic [ENT_W-1:0] ONE_Q16 = 32'h0001_0000;

    // reciprocal scale that makes the divider return the cofactor unchanged
    localparam logic [DM_W-1:0] UNIT_DMAG = {{(DM_W-ENT_W-1){1'b0}}, 1'b1, {ENT_W{1'b0}}};

    // cofactor k = a[CF_A[k]] * a[CF_B[k]] - a[CF_C[k]] * a[CF_D[k]]
    localparam int CF_A [NLANE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CF_B [NLANE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CF_C [NLANE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CF_D [NLANE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // first-column cofactors used in the first-row expansion
    localparam int TOP_COF [3] = '{0, 3, 6};

    typedef enum logic [1:0] {
        ST_INV  = 2'd0,
        ST_UNIT = 2'd1,
        ST_SING = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    typedef struct packed {
        logic [NLANE-1:0][COF_W-1:0] cof;
        logic [DM_W-1:0]             dmag;
        logic                        dneg;
        logic                        unit;
        logic                        zero;
    } fq_entry_t;

endpackage

`default_nettype wire

/* rtl/m3i_in_if.sv */
`default_nettype none

interface m3i_in_if import m3i_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ENT_W-1:0] m_r0c0;
    logic signed [ENT_W-1:0] m_r0c1;
    logic signed [ENT_W-1:0] m_r0c2;
    logic signed [ENT_W-1:0] m_r1c0;
    logic signed [ENT_W-1:0] m_r1c1;
    logic signed [ENT_W-1:0] m_r1c2;
    logic signed [ENT_W-1:0] m_r2c0;
    logic signed [ENT_W-1:0] m_r2c1;
    logic signed [ENT_W-1:0] m_r2c2;

    modport source (
        output valid,
        input  ready,
        output m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
    );

    modport sink (
        input  valid,
        output ready,
        input  m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
    );
endinterface

`default_nettype wire

/* rtl/m3i_out_if.sv */
`default_nettype none

interface m3i_out_if import m3i_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ENT_W-1:0] inv_r0c0;
    logic signed [ENT_W-1:0] inv_r0c1;
    logic signed [ENT_W-1:0] inv_r0c2;
    logic signed [ENT_W-1:0] inv_r1c0;
    logic signed [ENT_W-1:0] inv_r1c1;
    logic signed [ENT_W-1:0] inv_r1c2;
    logic signed [ENT_W-1:0] inv_r2c0;
    logic signed [ENT_W-1:0] inv_r2c1;
    logic signed [ENT_W-1:0] inv_r2c2;
    status_t                 status;

    modport source (
        output valid,
        input  ready,
        output inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, status
    );

    modport sink (
        input  valid,
        output ready,
        input  inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, status
    );
endinterface

`default_nettype wire

/* rtl/m3i_front.sv */
`default_nettype none

module m3i_front import m3i_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    m3i_in_if.sink    in_ch,
    output logic      push_valid,
    input  logic      push_ready,
    output fq_entry_t push_data
);

    localparam int NST = 7;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_in;
    logic [NST:0]   rdy;

    logic signed [ENT_W-1:0] a_in    [NLANE];
    logic signed [ENT_W-1:0] a0_reg  [NLANE];
    logic signed [ENT_W-1:0] raw1_reg [NLANE];
    logic signed [COF_W-1:0] pp1_reg [NLANE];
    logic signed [COF_W-1:0] pn1_reg [NLANE];
    logic                    unit1_reg;
    logic signed [COF_W-1:0] cof2_reg [NLANE];
    logic signed [ENT_W-1:0] top2_reg [3];
    logic                    unit2_reg;
    logic signed [COF_W:0]   plo3_reg [3];
    logic signed [COF_W-1:0] phi3_reg [3];
    logic signed [COF_W-1:0] cof3_reg [NLANE];
    logic                    unit3_reg;
    logic signed [DET_W-1:0] term4_reg [3];
    logic signed [COF_W-1:0] cof4_reg [NLANE];
    logic                    unit4_reg;
    logic signed [DET_W-1:0] det5_reg;
    logic signed [COF_W-1:0] cof5_reg [NLANE];
    logic                    unit5_reg;
    fq_entry_t               ent6_reg;
    fq_entry_t               ent6_next;
    logic [DET_W-1:0]        det_abs;

    assign a_in[0] = in_ch.m_r0c0;
    assign a_in[1] = in_ch.m_r0c1;
    assign a_in[2] = in_ch.m_r0c2;
    assign a_in[3] = in_ch.m_r1c0;
    assign a_in[4] = in_ch.m_r1c1;
    assign a_in[5] = in_ch.m_r1c2;
    assign a_in[6] = in_ch.m_r2c0;
    assign a_in[7] = in_ch.m_r2c1;
    assign a_in[8] = in_ch.m_r2c2;

    assign rdy[NST] = push_ready;

    genvar s;
    for (s = 0; s < NST; s++)
    begin : g_rdy
        assign rdy[s] = !vld_reg[s] || rdy[s+1];
    end

    assign vld_in      = {vld_reg[NST-2:0], in_ch.valid};
    assign in_ch.ready = rdy[0];
    assign push_valid  = vld_reg[NST-1];
    assign push_data   = ent6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int k = 0; k < NLANE; k++)
            begin
                a0_reg[k] <= a_in[k];
            end
        end
        if (rdy[1])
        begin
            unit1_reg <= (a0_reg[0] == ONE_Q16) && (a0_reg[4] == ONE_Q16)
                         && (a0_reg[8] == ONE_Q16);
            for (int k = 0; k < NLANE; k++)
            begin
                raw1_reg[k] <= a0_reg[k];
                pp1_reg[k]  <= COF_W'(a0_reg[CF_A[k]]) * COF_W'(a0_reg[CF_B[k]]);
                pn1_reg[k]  <= COF_W'(a0_reg[CF_C[k]]) * COF_W'(a0_reg[CF_D[k]]);
            end
        end
        if (rdy[2])
        begin
            unit2_reg <= unit1_reg;
            for (int k = 0; k < NLANE; k++)
            begin
                cof2_reg[k] <= unit1_reg ? COF_W'(raw1_reg[k]) : pp1_reg[k] - pn1_reg[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                top2_reg[j] <= raw1_reg[j];
            end
        end
        if (rdy[3])
        begin
            unit3_reg <= unit2_reg;
            cof3_reg  <= cof2_reg;
            for (int j = 0; j < 3; j++)
            begin
                plo3_reg[j] <= (COF_W+1)'(top2_reg[j])
                               * (COF_W+1)'($signed({1'b0, cof2_reg[TOP_COF[j]][ENT_W-1:0]}));
                phi3_reg[j] <= COF_W'(top2_reg[j])
                               * COF_W'($signed(cof2_reg[TOP_COF[j]][COF_W-1:ENT_W]));
            end
        end
        if (rdy[4])
        begin
            unit4_reg <= unit3_reg;
            cof4_reg  <= cof3_reg;
            for (int j = 0; j < 3; j++)
            begin
                term4_reg[j] <= (DET_W'(phi3_reg[j]) <<< ENT_W) + DET_W'(plo3_reg[j]);
            end
        end
        if (rdy[5])
        begin
            unit5_reg <= unit4_reg;
            cof5_reg  <= cof4_reg;
            det5_reg  <= term4_reg[0] + term4_reg[1] + term4_reg[2];
        end
        if (rdy[6])
        begin
            ent6_reg <= ent6_next;
        end
    end

    always_comb
    begin
        det_abs = det5_reg[DET_W-1] ? -det5_reg : det5_reg;
        for (int k = 0; k < NLANE; k++)
        begin
            ent6_next.cof[k] = cof5_reg[k];
        end
        ent6_next.dmag = unit5_reg ? UNIT_DMAG : det_abs[DM_W-1:0];
        ent6_next.dneg = !unit5_reg && det5_reg[DET_W-1];
        ent6_next.unit = unit5_reg;
        ent6_next.zero = !unit5_reg && (det5_reg == '0);
    end

endmodule

`default_nettype wire

/* rtl/m3i_queue.sv */
`default_nettype none

module m3i_queue import m3i_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  fq_entry_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output fq_entry_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    fq_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    logic             pop;

    assign push_ready = cnt_reg != FULL_CNT;
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("queue count above depth");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

/* rtl/m3i_back.sv */
`default_nettype none

module m3i_back import m3i_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  fq_entry_t pop_data,
    m3i_out_if.source out_ch
);

    localparam int NDIV = NQ;
    localparam logic [QR_W-1:0] LIM_POS = {{(QR_W-ENT_W+1){1'b0}}, {(ENT_W-1){1'b1}}};
    localparam logic [QR_W-1:0] LIM_NEG = {{(QR_W-ENT_W){1'b0}}, 1'b1, {(ENT_W-1){1'b0}}};

    logic [NDIV+1:0] vld_reg;
    logic [NDIV+1:0] vld_in;
    logic [NDIV+2:0] rdy;

    logic [DM_W-1:0] rem_reg  [NDIV+1][NLANE];
    logic [DM_W-1:0] rem_next [NDIV+1][NLANE];
    logic [NQ-1:0]   q_reg    [NDIV+1][NLANE];
    logic [NQ-1:0]   q_next   [NDIV+1][NLANE];
    logic            neg_reg  [NDIV+1][NLANE];
    logic            neg_next [NDIV+1][NLANE];
    logic            sat0_reg [NDIV+1][NLANE];
    logic            sat0_next [NDIV+1][NLANE];
    logic            lsb_reg  [NLANE];
    logic            lsb_next [NLANE];
    logic [DM_W-1:0] d_reg    [NDIV+1];
    logic            unit_reg [NDIV+1];
    logic            zero_reg [NDIV+1];

    logic [ENT_W-1:0] inv_reg  [NLANE];
    logic [ENT_W-1:0] inv_next [NLANE];
    status_t          status_reg, status_next;

    assign rdy[NDIV+2] = out_ch.ready;

    genvar s;
    for (s = 0; s <= NDIV + 1; s++)
    begin : g_rdy
        assign rdy[s] = !vld_reg[s] || rdy[s+1];
    end

    assign vld_in    = {vld_reg[NDIV:0], pop_valid};
    assign pop_ready = rdy[0];

    always_comb
    begin
        logic [COF_W-1:0] cm;
        logic             cneg;
        logic [DM_W:0]    sh;
        logic             ge;
        logic [DM_W:0]    diff;
        for (int l = 0; l < NLANE; l++)
        begin
            cneg = pop_data.cof[l][COF_W-1];
            cm   = cneg ? (~pop_data.cof[l] + 1'b1) : pop_data.cof[l];
            rem_next[0][l]  = {{(DM_W-COF_W+1){1'b0}}, cm[COF_W-1:1]};
            lsb_next[l]     = cm[0];
            q_next[0][l]    = '0;
            neg_next[0][l]  = cneg ^ pop_data.dneg;
            sat0_next[0][l] = {{(DM_W+1-COF_W){1'b0}}, cm} >= {pop_data.dmag, 1'b0};
        end
        for (int t = 1; t <= NDIV; t++)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                sh   = {rem_reg[t-1][l], (t == 1) ? lsb_reg[l] : 1'b0};
                ge   = sh >= {1'b0, d_reg[t-1]};
                diff = sh - {1'b0, d_reg[t-1]};
                rem_next[t][l]  = ge ? diff[DM_W-1:0] : sh[DM_W-1:0];
                q_next[t][l]    = {q_reg[t-1][l][NQ-2:0], ge};
                neg_next[t][l]  = neg_reg[t-1][l];
                sat0_next[t][l] = sat0_reg[t-1][l];
            end
        end
    end

    always_comb
    begin
        logic            rnd;
        logic [QR_W-1:0] qr;
        logic [QR_W-1:0] lim;
        logic            sat;
        logic            any_sat;
        logic [ENT_W-1:0] mag;
        any_sat = 1'b0;
        for (int l = 0; l < NLANE; l++)
        begin
            rnd = {rem_reg[NDIV][l], 1'b0} >= {1'b0, d_reg[NDIV]};
            qr  = {1'b0, q_reg[NDIV][l]} + QR_W'(rnd);
            lim = neg_reg[NDIV][l] ? LIM_NEG : LIM_POS;
            sat = sat0_reg[NDIV][l] || (qr > lim);
            mag = sat ? lim[ENT_W-1:0] : qr[ENT_W-1:0];
            inv_next[l] = zero_reg[NDIV] ? '0 : (neg_reg[NDIV][l] ? -mag : mag);
            any_sat = any_sat || sat;
        end
        if (unit_reg[NDIV])
        begin
            status_next = ST_UNIT;
        end
        else if (zero_reg[NDIV])
        begin
            status_next = ST_SING;
        end
        else if (any_sat)
        begin
            status_next = ST_SAT;
        end
        else
        begin
            status_next = ST_INV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i <= NDIV + 1; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            d_reg[0]    <= pop_data.dmag;
            unit_reg[0] <= pop_data.unit;
            zero_reg[0] <= pop_data.zero;
            lsb_reg     <= lsb_next;
        end
        for (int t = 1; t <= NDIV; t++)
        begin
            if (rdy[t])
            begin
                d_reg[t]    <= d_reg[t-1];
                unit_reg[t] <= unit_reg[t-1];
                zero_reg[t] <= zero_reg[t-1];
            end
        end
        for (int t = 0; t <= NDIV; t++)
        begin
            if (rdy[t])
            begin
                rem_reg[t]  <= rem_next[t];
                q_reg[t]    <= q_next[t];
                neg_reg[t]  <= neg_next[t];
                sat0_reg[t] <= sat0_next[t];
            end
        end
        if (rdy[NDIV+1])
        begin
            inv_reg    <= inv_next;
            status_reg <= status_next;
        end
    end

    assign out_ch.valid    = vld_reg[NDIV+1];
    assign out_ch.inv_r0c0 = inv_reg[0];
    assign out_ch.inv_r0c1 = inv_reg[1];
    assign out_ch.inv_r0c2 = inv_reg[2];
    assign out_ch.inv_r1c0 = inv_reg[3];
    assign out_ch.inv_r1c1 = inv_reg[4];
    assign out_ch.inv_r1c2 = inv_reg[5];
    assign out_ch.inv_r2c0 = inv_reg[6];
    assign out_ch.inv_r2c1 = inv_reg[7];
    assign out_ch.inv_r2c2 = inv_reg[8];
    assign out_ch.status   = status_reg;

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NDIV] |-> (rem_reg[NDIV][0] < d_reg[NDIV]) || zero_reg[NDIV]
                          || sat0_reg[NDIV][0])
        else $error("partial remainder not below divisor");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NDIV+1] && status_reg == ST_SING) |->
        (inv_reg[0] == '0 && inv_reg[4] == '0 && inv_reg[8] == '0))
        else $error("singular result with nonzero entries");

endmodule

`default_nettype wire

/* rtl/matrix3x3_inverse.sv */
// 3x3 matrix inverse, signed Q16.16 in and out.
// in_ch carries one matrix per transfer (nine entries, row major); out_ch
// carries the nine inverse entries and a status code: inverted, unit
// diagonal passed through, singular (all entries zero) or saturated.
// An input transfer passes through 7 front stages (products,
// cofactors, determinant), the queue, and 35 back stages
// (prep, 33 restoring divide steps, one bit per stage for all nine
// entries in parallel, and the rounding/output register). Throughput
// is one matrix per cycle while out_ch is ready; every stage holds its
// item under stall and a bubble anywhere is filled, so in_ch stays
// ready while earlier results wait. When out_ch stalls, the back
// pipeline fills, then the queue of QUEUE_DEPTH entries, then the
// front pipeline, and only then does in_ch drop ready.
// Reset (rst_n low, asynchronous) empties all stages and the queue.
`default_nettype none

module matrix3x3_inverse import m3i_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    m3i_in_if.sink    in_ch,
    m3i_out_if.source out_ch
);

    logic      push_valid;
    logic      push_ready;
    fq_entry_t push_data;
    logic      pop_valid;
    logic      pop_ready;
    fq_entry_t pop_data;

    m3i_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    m3i_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    m3i_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

/* sim/matrix3x3_inverse_tb.sv */
module matrix3x3_inverse_tb;
    import m3i_pkg::*;

    typedef logic [NLANE-1:0][ENT_W-1:0] mat_t;

    typedef struct packed {
        mat_t    e;
        status_t st;
    } inv_res_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic calm = 1'b0;
    int   n_errors = 0;
    int   cycles = 0;

    inv_res_t pending_inv[$];

    m3i_in_if  in_ch();
    m3i_out_if out_ch();

    matrix3x3_inverse DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #10 clk = ~clk;

    initial
    begin
        in_ch.valid  = 1'b0;
        in_ch.m_r0c0 = '0;
        in_ch.m_r0c1 = '0;
        in_ch.m_r0c2 = '0;
        in_ch.m_r1c0 = '0;
        in_ch.m_r1c1 = '0;
        in_ch.m_r1c2 = '0;
        in_ch.m_r2c0 = '0;
        in_ch.m_r2c1 = '0;
        in_ch.m_r2c2 = '0;
        out_ch.ready = 1'b0;
    end

    function automatic inv_res_t invert(mat_t m);
        inv_res_t r;
        longint a[9];
        longint cof[9];
        logic signed [127:0] det;
        logic [127:0] dmag, num, q, rem, lim;
        logic [64:0] cm;
        logic dneg, neg, sat;
        if (m[0] == ONE_Q16 && m[4] == ONE_Q16 && m[8] == ONE_Q16)
        begin
            r.e = m;
            r.st = ST_UNIT;
            return r;
        end
        for (int k = 0; k < 9; k++)
            a[k] = $signed(m[k]);
        cof[0] = a[4] * a[8] - a[5] * a[7];
        cof[3] = a[5] * a[6] - a[3] * a[8];
        cof[6] = a[3] * a[7] - a[4] * a[6];
        cof[1] = a[2] * a[7] - a[1] * a[8];
        cof[4] = a[0] * a[8] - a[2] * a[6];
        cof[7] = a[1] * a[6] - a[0] * a[7];
        cof[2] = a[1] * a[5] - a[2] * a[4];
        cof[5] = a[2] * a[3] - a[0] * a[5];
        cof[8] = a[0] * a[4] - a[1] * a[3];
        det = 128'(a[0]) * 128'(cof[0]) + 128'(a[1]) * 128'(cof[3])
            + 128'(a[2]) * 128'(cof[6]);
        r.e = '0;
        if (det == 0)
        begin
            r.st = ST_SING;
            return r;
        end
        dneg = det[127];
        dmag = dneg ? -det : det;
        sat = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            if (cof[k] != 0)
            begin
                cm = cof[k][63] ? 65'd0 - {1'b1, cof[k]} : {1'b0, cof[k]};
                num = 128'(cm) << 32;
                q = num / dmag;
                rem = num % dmag;
                if ((rem << 1) >= dmag)
                    q = q + 1;
                neg = cof[k][63] ^ dneg;
                lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
                if (q > lim)
                begin
                    sat = 1'b1;
                    q = lim;
                end
                r.e[k] = neg ? 32'd0 - q[31:0] : q[31:0];
            end
        end
        r.st = sat ? ST_SAT : ST_INV;
        return r;
    endfunction

    task automatic report(string what, int idx, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("mismatch %s[%0d]: got %h want %h at cycle %0d", what, idx, got, want, cycles);
    endtask

    // one matrix per transfer; valid stays high across back-to-back items
    task automatic send_matrix(mat_t m);
        while (!calm && $urandom_range(99) < 34)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.m_r0c0 <= m[0];
        in_ch.m_r0c1 <= m[1];
        in_ch.m_r0c2 <= m[2];
        in_ch.m_r1c0 <= m[3];
        in_ch.m_r1c1 <= m[4];
        in_ch.m_r1c2 <= m[5];
        in_ch.m_r2c0 <= m[6];
        in_ch.m_r2c1 <= m[7];
        in_ch.m_r2c2 <= m[8];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_inv.push_back(invert(m));
    endtask

    always @(posedge clk)
        if (rst_n)
            out_ch.ready <= calm || ($urandom_range(99) >= 34);

    always @(posedge clk)
    begin
        mat_t got;
        inv_res_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d", cycles);
            $display("simulation failed");
            $finish;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.inv_r2c2, out_ch.inv_r2c1, out_ch.inv_r2c0,
                   out_ch.inv_r1c2, out_ch.inv_r1c1, out_ch.inv_r1c0,
                   out_ch.inv_r0c2, out_ch.inv_r0c1, out_ch.inv_r0c0};
            if (pending_inv.size() == 0)
                report("unexpected transfer", 0, got[0], 0);
            else
            begin
                want = pending_inv.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got[k] !== want.e[k])
                        report("inv", k, got[k], want.e[k]);
                if (out_ch.status !== want.st)
                    report("status", 0, 32'(out_ch.status), 32'(want.st));
            end
        end
    end

    function automatic logic [31:0] rand_entry(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 ** 19)) - 2 ** 18);
            2: return 32'($signed($urandom_range(0, 16)) - 8) << 16;
            default: return 32'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
        endcase
    endfunction

    function automatic mat_t rand_matrix(int kind);
        mat_t m;
        for (int k = 0; k < 9; k++)
            m[k] = rand_entry(kind);
        return m;
    endfunction

    task automatic test_directed();
        mat_t m;
        m = '0;
        send_matrix(m);
        m = {9{32'h8000_0000}};
        send_matrix(m);
        m = {9{32'h7fff_ffff}};
        send_matrix(m);
        m = {9{32'hffff_ffff}};
        send_matrix(m);
        m = '0;
        m[0] = ONE_Q16; m[4] = ONE_Q16; m[8] = ONE_Q16;
        send_matrix(m);
        m = rand_matrix(0);
        m[0] = ONE_Q16; m[4] = ONE_Q16; m[8] = ONE_Q16;
        send_matrix(m);
        m = '0;
        m[0] = ONE_Q16; m[4] = ONE_Q16; m[8] = 32'h0001_0001;
        send_matrix(m);
        m = '0;
        m[0] = 32'h0002_0000; m[4] = 32'hfffe_0000; m[8] = 32'h0000_8000;
        send_matrix(m);
        m = '0;
        m[0] = 32'd1; m[4] = 32'd1; m[8] = 32'd1;
        send_matrix(m);
        m = '0;
        m[0] = 32'h8000_0000; m[4] = 32'h7fff_ffff; m[8] = 32'd3;
        send_matrix(m);
        m = '0;
        m[0] = 32'h8000_0000; m[4] = 32'h8000_0000; m[8] = 32'h8000_0000;
        send_matrix(m);
        m = rand_matrix(1);
        m[3] = m[0]; m[4] = m[1]; m[5] = m[2];
        send_matrix(m);
        m = rand_matrix(2);
        m[6] = m[0] + m[3]; m[7] = m[1] + m[4]; m[8] = m[2] + m[5];
        send_matrix(m);
        m = '0;
        m[0] = 32'h0003_0000; m[4] = 32'h0003_0000; m[8] = 32'h0003_0000;
        send_matrix(m);
        m = '0;
        m[2] = ONE_Q16; m[4] = 32'hffff_0000; m[6] = 32'h0004_0000;
        send_matrix(m);
        m = rand_matrix(0);
        m[4] = 32'h8000_0000; m[8] = 32'h8000_0000; m[5] = 32'h7fff_ffff; m[7] = 32'h7fff_ffff;
        send_matrix(m);
        for (int k = 0; k < 4; k++)
            send_matrix(rand_matrix(k));
    endtask

    task automatic test_random(int count);
        mat_t m;
        int kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 5);
            m = rand_matrix(kind > 3 ? 1 : kind);
            case ($urandom_range(0, 9))
                0: begin m[0] = ONE_Q16; m[4] = ONE_Q16; m[8] = ONE_Q16; end
                1: begin m[6] = m[0]; m[7] = m[1]; m[8] = m[2]; end
                2: m[$urandom_range(0, 8)] = ONE_Q16;
                3: begin m[1] = 0; m[2] = 0; m[5] = 0; end
                default: ;
            endcase
            send_matrix(m);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(900);
        calm <= 1'b1;
        test_random(300);
        calm <= 1'b0;
        test_random(730);
        in_ch.valid <= 1'b0;
        while (pending_inv.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
